>>> design/ffp_pkg.sv
`default_nettype none

package ffp_pkg;

    // Frame layout.
    localparam int unsigned PAYLOAD_BYTES = 8;
    localparam int unsigned IDX_W         = $clog2(PAYLOAD_BYTES);

    localparam logic [7:0] HDR_BYTE  = 8'hFC;
    localparam logic [7:0] TRL_BYTE  = 8'hDF;
    localparam logic [7:0] KIND_LOW  = 8'd1;
    localparam logic [7:0] KIND_HIGH = 8'd5;

    // One decoded frame as it leaves the parser.
    typedef struct packed {
        logic [2:0]  frame_kind;
        logic [15:0] word_zero;
        logic [15:0] word_one;
        logic [15:0] word_two;
        logic [15:0] word_three;
    } t_frame;

endpackage

`default_nettype wire

>>> design/ffp_if.sv
`default_nettype none

// Byte channel from the serial receiver.
interface ffp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// Decoded frame channel.
interface ffp_frame_if;
    logic        valid;
    logic        ready;
    logic [2:0]  frame_kind;
    logic [15:0] word_zero;
    logic [15:0] word_one;
    logic [15:0] word_two;
    logic [15:0] word_three;

    modport source (output valid, output frame_kind, output word_zero, output word_one,
                    output word_two, output word_three, input ready);
    modport sink (input valid, input frame_kind, input word_zero, input word_one,
                  input word_two, input word_three, output ready);
endinterface

`default_nettype wire

>>> design/ffp_in_stage.sv
`default_nettype none

module ffp_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    output logic            o_ready,
    input  wire logic       i_space,
    output logic            o_step,
    output logic [7:0]      o_byte
);
    import ffp_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_valid;

    // The held byte is consumed whenever the result side can take a result.
    assign o_step  = r_valid && i_space;
    assign o_ready = !r_valid || i_space;
    assign o_byte  = r_byte;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

`default_nettype wire

>>> design/ffp_parser.sv
`default_nettype none

module ffp_parser (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire logic [7:0] i_byte,
    output logic           o_hit,
    output ffp_pkg::t_frame o_frame
);
    import ffp_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_KIND,
        PH_DATA,
        PH_CHECK,
        PH_TRAIL
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_xor, n_xor;
    logic [2:0]       r_kind, n_kind;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [7:0]       r_store [PAYLOAD_BYTES];

    always_comb begin
        n_phase = r_phase;
        n_xor   = r_xor;
        n_kind  = r_kind;
        n_idx   = r_idx;
        case (r_phase)
            PH_KIND: begin
                if (i_byte >= KIND_LOW && i_byte <= KIND_HIGH) begin
                    n_kind  = i_byte[2:0];
                    n_xor   = r_xor ^ i_byte;
                    n_idx   = '0;
                    n_phase = PH_DATA;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_DATA: begin
                n_xor = r_xor ^ i_byte;
                if (r_idx == IDX_W'(PAYLOAD_BYTES - 1)) begin
                    n_idx   = '0;
                    n_phase = PH_CHECK;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            PH_CHECK: begin
                n_phase = (i_byte == r_xor) ? PH_TRAIL : PH_HUNT;
            end
            PH_TRAIL: begin
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
                if (i_byte == HDR_BYTE) begin
                    n_xor   = HDR_BYTE;
                    n_phase = PH_KIND;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_xor   <= '0;
            r_kind  <= '0;
            r_idx   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_xor   <= n_xor;
            r_kind  <= n_kind;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && r_phase == PH_DATA) begin
            r_store[r_idx] <= i_byte;
        end
    end

    // A frame is complete when a correct trailer arrives after a good checksum.
    assign o_hit = i_step && r_phase == PH_TRAIL && i_byte == TRL_BYTE;

    always_comb begin
        o_frame.frame_kind = r_kind;
        o_frame.word_zero  = {r_store[0], r_store[1]};
        o_frame.word_one   = {r_store[2], r_store[3]};
        o_frame.word_two   = {r_store[4], r_store[5]};
        o_frame.word_three = {r_store[6], r_store[7]};
    end

endmodule

`default_nettype wire

>>> design/ffp_out_stage.sv
`default_nettype none

module ffp_out_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire ffp_pkg::t_frame i_frame,
    output logic                 o_space,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output ffp_pkg::t_frame      o_frame
);
    import ffp_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_frame r_frame;

    // Space for a new result whenever the register is empty or being emptied.
    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_frame = r_frame;

    always_comb begin
        n_valid = r_valid;
        if (o_space) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_frame <= i_frame;
        end
    end

endmodule

`default_nettype wire

>>> design/fixed_frame_parser_xor_check_unit.sv
`default_nettype none

// Fixed-length frame parser with XOR check. Received serial bytes arrive one
// request at a time on i_rx; the block hunts for the header byte 0xFC, takes a
// type byte from 1 to 5, collects eight payload bytes, checks a checksum byte
// against the XOR of header, type and payload, and requires the trailer 0xDF.
// A bad type, checksum or trailer drops the frame and returns to the hunt
// without rechecking that byte as a header. Each good frame gives one request
// on o_frame carrying the type and the payload as four big-endian 16-bit
// words. The block takes one byte per clock cycle: every byte passes through
// an input register, compare and XOR logic that updates the parse state, and
// an output register, so a frame is presented on o_frame from the output
// register once its trailer byte has passed the input register and the parse
// logic. Throughput drops below one byte per cycle only while a finished frame
// waits in the output register and the sink holds ready low.
module fixed_frame_parser_xor_check_unit (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ffp_byte_if.sink     i_rx,
    ffp_frame_if.source  o_frame
);
    import ffp_pkg::*;

    logic       space;
    logic       step;
    logic [7:0] held_byte;
    logic       hit;
    t_frame     parsed;
    t_frame     out_frame;
    logic       out_valid;

    // Input register: holds one byte until the parser consumes it.
    ffp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx.valid),
        .i_byte  (i_rx.rx_byte),
        .o_ready (i_rx.ready),
        .i_space (space),
        .o_step  (step),
        .o_byte  (held_byte)
    );

    // Parse state, running XOR and payload store.
    ffp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (held_byte),
        .o_hit   (hit),
        .o_frame (parsed)
    );

    // Result register towards the sink.
    ffp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (hit),
        .i_frame (parsed),
        .o_space (space),
        .o_valid (out_valid),
        .i_ready (o_frame.ready),
        .o_frame (out_frame)
    );

    assign o_frame.valid      = out_valid;
    assign o_frame.frame_kind = out_frame.frame_kind;
    assign o_frame.word_zero  = out_frame.word_zero;
    assign o_frame.word_one   = out_frame.word_one;
    assign o_frame.word_two   = out_frame.word_two;
    assign o_frame.word_three = out_frame.word_three;

endmodule

`default_nettype wire
